FILE: hw/rtl/ipv6_transport_header_parser_assert.svh
// Assertion helpers for the IPv6 transport header parser.
// Both macros assume a clock named clk and an active-low reset named rst_n in scope.
`ifndef IPV6_TRANSPORT_HEADER_PARSER_ASSERT_SVH
`define IPV6_TRANSPORT_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTH

// prop must hold at every clock edge outside reset
`define IPHP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// cond must never be true at a clock edge outside reset
`define IPHP_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define IPHP_ASSERT(label, prop, msg)
`define IPHP_NEVER(label, cond, msg)

`endif

`endif

FILE: hw/rtl/iphp_pkg.sv
package iphp_pkg;

    localparam int unsigned MAX_PACKET_BYTES_DEF = 65535;
    localparam int unsigned MID_DEPTH = 4;
    localparam int unsigned OUT_DEPTH = 2;

    localparam logic [15:0] FIXED_LAST = 16'd39;
    localparam logic [15:0] FIXED_LEN  = 16'd40;
    localparam logic [15:0] TCP_LAST   = 16'd19;
    localparam logic [15:0] UDP_LAST   = 16'd7;
    localparam logic [11:0] EXT_BIAS   = 12'd6;

    localparam logic [7:0] NH_HOP   = 8'd0;
    localparam logic [7:0] NH_TCP   = 8'd6;
    localparam logic [7:0] NH_UDP   = 8'd17;
    localparam logic [7:0] NH_ROUTE = 8'd43;
    localparam logic [7:0] NH_FRAG  = 8'd44;
    localparam logic [7:0] NH_DEST  = 8'd60;

    localparam logic [3:0] VERSION_IPV4 = 4'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_IPV4  = 2'd1;
    localparam logic [1:0] STAT_NONE  = 2'd2;
    localparam logic [1:0] STAT_TRUNC = 2'd3;

    typedef enum logic [2:0] {
        PH_FIXED,
        PH_IPV4,
        PH_EXT,
        PH_TRANS,
        PH_DONE,
        PH_OTHER
    } phase_t;

    // one packet byte, tagged by the front end
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        take;
        logic [15:0] pos;
    } beat_t;

    typedef struct packed {
        logic [1:0]  parse_status;
        logic [7:0]  proto_code;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [7:0]  tclass;
        logic [19:0] flow_label;
        logic [63:0] src_addr_high;
        logic [63:0] src_addr_low;
        logic [63:0] dst_addr_high;
        logic [63:0] dst_addr_low;
        logic [15:0] payload_offset;
        logic [15:0] payload_length;
    } record_t;

    function automatic phase_t dispatch_phase(input logic [7:0] code);
        phase_t ph;
        unique case (code) inside
            NH_HOP, NH_ROUTE, NH_FRAG, NH_DEST: ph = PH_EXT;
            NH_TCP, NH_UDP:                     ph = PH_TRANS;
            default:                            ph = PH_OTHER;
        endcase
        return ph;
    endfunction

endpackage

FILE: hw/rtl/ipv6_transport_header_parser.sv
// IPv6 transport header parser. Takes one packet byte per cycle, starting at the IP
// header, walks the fixed header and any hop-by-hop, routing, fragment and
// destination-options headers, captures TCP/UDP ports, and puts one record on the
// result queue for the beat flagged last_byte. A front stage counts byte positions
// and tags each beat; a 4-entry queue feeds the parser back end, which writes records
// into a 2-entry result queue. Sustained rate is one byte per cycle; a last byte is
// written into the 4-entry queue, and its record into the result queue when the back
// end pops it. Intake stalls only once the 4-entry queue has filled behind a last byte
// that waits for room in a full result queue. Bytes beyond MAX_PACKET_BYTES are
// passed on uncounted and unparsed; the last byte still closes the packet.
`include "ipv6_transport_header_parser_assert.svh"

module ipv6_transport_header_parser #(
    parameter int unsigned MAX_PACKET_BYTES = iphp_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  packet_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  parse_status,
    output logic [7:0]  proto_code,
    output logic [15:0] source_port,
    output logic [15:0] destination_port,
    output logic [7:0]  tclass,
    output logic [19:0] flow_label,
    output logic [63:0] src_addr_high,
    output logic [63:0] src_addr_low,
    output logic [63:0] dst_addr_high,
    output logic [63:0] dst_addr_low,
    output logic [15:0] payload_offset,
    output logic [15:0] payload_length
);

    iphp_pkg::beat_t   front_beat;
    iphp_pkg::beat_t   mid_beat;
    iphp_pkg::record_t back_rec;
    iphp_pkg::record_t out_rec;

    logic in_accept;
    logic mid_full;
    logic mid_empty;
    logic mid_pop;
    logic out_push;
    logic out_full;

    assign in_accept = push && !mid_full;
    assign full      = mid_full;

    iphp_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_accept),
        .packet_byte (packet_byte),
        .last_byte   (last_byte),
        .beat        (front_beat)
    );

    iphp_fifo #(
        .WIDTH($bits(iphp_pkg::beat_t)),
        .DEPTH(iphp_pkg::MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (in_accept),
        .wr_data (front_beat),
        .full    (mid_full),
        .pop     (mid_pop),
        .rd_data (mid_beat),
        .empty   (mid_empty)
    );

    iphp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (mid_beat),
        .beat_valid (!mid_empty),
        .out_full   (out_full),
        .beat_pop   (mid_pop),
        .rec_push   (out_push),
        .rec        (back_rec)
    );

    iphp_fifo #(
        .WIDTH($bits(iphp_pkg::record_t)),
        .DEPTH(iphp_pkg::OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (out_push),
        .wr_data (back_rec),
        .full    (out_full),
        .pop     (pop),
        .rd_data (out_rec),
        .empty   (empty)
    );

    assign parse_status     = out_rec.parse_status;
    assign proto_code       = out_rec.proto_code;
    assign source_port      = out_rec.source_port;
    assign destination_port = out_rec.destination_port;
    assign tclass           = out_rec.tclass;
    assign flow_label       = out_rec.flow_label;
    assign src_addr_high    = out_rec.src_addr_high;
    assign src_addr_low     = out_rec.src_addr_low;
    assign dst_addr_high    = out_rec.dst_addr_high;
    assign dst_addr_low     = out_rec.dst_addr_low;
    assign payload_offset   = out_rec.payload_offset;
    assign payload_length   = out_rec.payload_length;

    `IPHP_NEVER(a_out_overflow, out_push && out_full, "record pushed into full result queue")
    `IPHP_NEVER(a_pop_nothing, mid_pop && mid_empty,
        "back end consumed a beat that was not there")
    `IPHP_ASSERT(a_ports_zero,
        (!empty && parse_status != iphp_pkg::STAT_OK)
            |-> (source_port == 16'd0 && destination_port == 16'd0),
        "ports nonzero on unparsed record")
    `IPHP_ASSERT(a_ipv4_blank,
        (!empty && parse_status == iphp_pkg::STAT_IPV4)
            |-> (proto_code == 8'd0 && payload_offset == 16'd0 && payload_length == 16'd0),
        "ipv4 record carries fields")

endmodule

FILE: hw/rtl/iphp_fifo.sv
module iphp_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hw/rtl/iphp_front.sv
module iphp_front #(
    parameter int unsigned MAX_PACKET_BYTES = iphp_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      packet_byte,
    input  logic            last_byte,
    output iphp_pkg::beat_t beat
);

    logic [15:0] pos_reg, pos_next;
    logic        take;

    // bytes past the size limit are passed on but not counted or parsed
    assign take = (pos_reg < 16'(MAX_PACKET_BYTES));

    always_comb
    begin
        beat.data = packet_byte;
        beat.last = last_byte;
        beat.take = take;
        beat.pos  = pos_reg;
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                pos_next = '0;
            end
            else if (take)
            begin
                pos_next = pos_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

FILE: hw/rtl/iphp_back.sv
module iphp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  iphp_pkg::beat_t   beat,
    input  logic              beat_valid,
    input  logic              out_full,
    output logic              beat_pop,
    output logic              rec_push,
    output iphp_pkg::record_t rec
);

    iphp_pkg::phase_t phase_reg, phase_upd, phase_next;

    logic [7:0]  nh_reg, nh_upd, nh_next;
    logic [7:0]  ext_code_reg, ext_code_upd, ext_code_next;
    logic [11:0] ext_left_reg, ext_left_upd, ext_left_next;
    logic [15:0] hdr_end_reg, hdr_end_upd, hdr_end_next;
    logic [31:0] fw_reg, fw_upd, fw_next;
    logic [63:0] src_hi_reg, src_hi_upd, src_hi_next;
    logic [63:0] src_lo_reg, src_lo_upd, src_lo_next;
    logic [63:0] dst_hi_reg, dst_hi_upd, dst_hi_next;
    logic [63:0] dst_lo_reg, dst_lo_upd, dst_lo_next;
    logic [31:0] ports_reg, ports_upd, ports_next;

    logic        upd;
    logic        close;
    logic        is_ipv4;
    logic [15:0] pos;
    logic [15:0] rel;
    logic [15:0] trans_last;
    logic [11:0] ext_left_calc;
    logic        ext_close;
    logic [15:0] end_pos;

    // a last beat waits until the result queue has room
    assign beat_pop = beat_valid && (!beat.last || !out_full);
    assign upd      = beat_pop && beat.take;
    assign close    = beat_pop && beat.last;
    assign rec_push = close;

    assign pos        = beat.pos;
    assign rel        = pos - hdr_end_reg;
    assign is_ipv4    = (pos == 16'd0) && (beat.data[7:4] == iphp_pkg::VERSION_IPV4);
    assign trans_last = (nh_reg == iphp_pkg::NH_TCP) ? iphp_pkg::TCP_LAST : iphp_pkg::UDP_LAST;
    assign end_pos    = beat.take ? pos + 16'd1 : pos;

    // length counter of an extension header: (len+1)*8 - 2 bytes after the len byte
    always_comb
    begin
        if (rel == 16'd0)
        begin
            ext_left_calc = ext_left_reg;
        end
        else if (rel == 16'd1)
        begin
            ext_left_calc = {1'b0, beat.data, 3'b000} + iphp_pkg::EXT_BIAS;
        end
        else if (ext_left_reg != '0)
        begin
            ext_left_calc = ext_left_reg - 12'd1;
        end
        else
        begin
            ext_left_calc = ext_left_reg;
        end
    end

    assign ext_close = (rel != 16'd0) && (ext_left_calc == '0);

    // parse phase
    always_comb
    begin
        phase_upd = phase_reg;
        if (upd)
        begin
            unique case (phase_reg)
                iphp_pkg::PH_FIXED:
                begin
                    if (is_ipv4)
                    begin
                        phase_upd = iphp_pkg::PH_IPV4;
                    end
                    else if (pos == iphp_pkg::FIXED_LAST)
                    begin
                        phase_upd = iphp_pkg::dispatch_phase(nh_reg);
                    end
                end
                iphp_pkg::PH_EXT:
                begin
                    if (ext_close)
                    begin
                        phase_upd = iphp_pkg::dispatch_phase(ext_code_reg);
                    end
                end
                iphp_pkg::PH_TRANS:
                begin
                    if (rel == trans_last)
                    begin
                        phase_upd = iphp_pkg::PH_DONE;
                    end
                end
                iphp_pkg::PH_IPV4, iphp_pkg::PH_DONE, iphp_pkg::PH_OTHER:
                begin
                    phase_upd = phase_reg;
                end
                default:
                begin
                    phase_upd = phase_reg;
                end
            endcase
        end
        phase_next = close ? iphp_pkg::PH_FIXED : phase_upd;
    end

    // header fields and record
    always_comb
    begin
        nh_upd       = nh_reg;
        ext_code_upd = ext_code_reg;
        ext_left_upd = ext_left_reg;
        hdr_end_upd  = hdr_end_reg;
        fw_upd       = fw_reg;
        src_hi_upd   = src_hi_reg;
        src_lo_upd   = src_lo_reg;
        dst_hi_upd   = dst_hi_reg;
        dst_lo_upd   = dst_lo_reg;
        ports_upd    = ports_reg;

        if (upd)
        begin
            case (phase_reg)
                iphp_pkg::PH_FIXED:
                begin
                    if (!is_ipv4)
                    begin
                        if (pos < 16'd4)
                        begin
                            fw_upd = {fw_reg[23:0], beat.data};
                        end
                        else if (pos == 16'd6)
                        begin
                            nh_upd = beat.data;
                        end
                        else if (pos >= 16'd8 && pos < 16'd16)
                        begin
                            src_hi_upd = {src_hi_reg[55:0], beat.data};
                        end
                        else if (pos >= 16'd16 && pos < 16'd24)
                        begin
                            src_lo_upd = {src_lo_reg[55:0], beat.data};
                        end
                        else if (pos >= 16'd24 && pos < 16'd32)
                        begin
                            dst_hi_upd = {dst_hi_reg[55:0], beat.data};
                        end
                        else if (pos >= 16'd32 && pos < iphp_pkg::FIXED_LEN)
                        begin
                            dst_lo_upd = {dst_lo_reg[55:0], beat.data};
                        end
                        if (pos == iphp_pkg::FIXED_LAST)
                        begin
                            hdr_end_upd  = iphp_pkg::FIXED_LEN;
                            ext_left_upd = '0;
                        end
                    end
                end
                iphp_pkg::PH_EXT:
                begin
                    if (rel == 16'd0)
                    begin
                        ext_code_upd = beat.data;
                    end
                    ext_left_upd = ext_left_calc;
                    if (ext_close)
                    begin
                        hdr_end_upd  = pos + 16'd1;
                        nh_upd       = ext_code_reg;
                        ext_left_upd = '0;
                    end
                end
                iphp_pkg::PH_TRANS:
                begin
                    if (rel < 16'd4)
                    begin
                        ports_upd = {ports_reg[23:0], beat.data};
                    end
                    if (rel == trans_last)
                    begin
                        hdr_end_upd = pos + 16'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        rec = '0;
        case (phase_upd)
            iphp_pkg::PH_IPV4:
            begin
                rec.parse_status = iphp_pkg::STAT_IPV4;
            end
            iphp_pkg::PH_FIXED:
            begin
                rec.parse_status = iphp_pkg::STAT_TRUNC;
            end
            default:
            begin
                if (phase_upd == iphp_pkg::PH_DONE)
                begin
                    rec.parse_status     = iphp_pkg::STAT_OK;
                    rec.source_port      = ports_upd[31:16];
                    rec.destination_port = ports_upd[15:0];
                end
                else if (phase_upd == iphp_pkg::PH_TRANS)
                begin
                    rec.parse_status = iphp_pkg::STAT_TRUNC;
                end
                else
                begin
                    rec.parse_status = iphp_pkg::STAT_NONE;
                end
                rec.proto_code     = nh_upd;
                rec.tclass         = fw_upd[27:20];
                rec.flow_label     = fw_upd[19:0];
                rec.src_addr_high  = src_hi_upd;
                rec.src_addr_low   = src_lo_upd;
                rec.dst_addr_high  = dst_hi_upd;
                rec.dst_addr_low   = dst_lo_upd;
                rec.payload_offset = hdr_end_upd;
                rec.payload_length = end_pos - hdr_end_upd;
            end
        endcase

        nh_next       = close ? '0 : nh_upd;
        ext_code_next = close ? '0 : ext_code_upd;
        ext_left_next = close ? '0 : ext_left_upd;
        hdr_end_next  = close ? '0 : hdr_end_upd;
        fw_next       = close ? '0 : fw_upd;
        src_hi_next   = close ? '0 : src_hi_upd;
        src_lo_next   = close ? '0 : src_lo_upd;
        dst_hi_next   = close ? '0 : dst_hi_upd;
        dst_lo_next   = close ? '0 : dst_lo_upd;
        ports_next    = close ? '0 : ports_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= iphp_pkg::PH_FIXED;
            nh_reg       <= '0;
            ext_code_reg <= '0;
            ext_left_reg <= '0;
            hdr_end_reg  <= '0;
            fw_reg       <= '0;
            src_hi_reg   <= '0;
            src_lo_reg   <= '0;
            dst_hi_reg   <= '0;
            dst_lo_reg   <= '0;
            ports_reg    <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            nh_reg       <= nh_next;
            ext_code_reg <= ext_code_next;
            ext_left_reg <= ext_left_next;
            hdr_end_reg  <= hdr_end_next;
            fw_reg       <= fw_next;
            src_hi_reg   <= src_hi_next;
            src_lo_reg   <= src_lo_next;
            dst_hi_reg   <= dst_hi_next;
            dst_lo_reg   <= dst_lo_next;
            ports_reg    <= ports_next;
        end
    end

endmodule

FILE: tb/sv/ipv6_transport_header_parser_tb.sv
`timescale 1ns / 100ps

module ipv6_transport_header_parser_tb;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 200;
    localparam int TAIL_CYCLES  = 20;

    typedef logic [7:0] byte_q_t [$];

    // Mirrors the parser: follows the header chain byte by byte and queues the
    // record that each closing byte should produce.
    class parse_record_board;
        iphp_pkg::phase_t  phase;
        logic [15:0]       byte_pos;
        logic [7:0]        next_code;
        logic [7:0]        ext_code;
        logic [11:0]       ext_left;
        logic [15:0]       hdr_end;
        logic [31:0]       word0;
        logic [63:0]       src_addr [2];
        logic [63:0]       dst_addr [2];
        logic [31:0]       ports;
        iphp_pkg::record_t awaited_records [$];
        int                mismatch_count;

        function new();
            mismatch_count = 0;
            start_packet();
        endfunction

        function void start_packet();
            phase     = iphp_pkg::PH_FIXED;
            byte_pos  = '0;
            next_code = '0;
            ext_code  = '0;
            ext_left  = '0;
            hdr_end   = '0;
            word0     = '0;
            src_addr  = '{default: '0};
            dst_addr  = '{default: '0};
            ports     = '0;
        endfunction

        function void select_next();
            if (next_code == iphp_pkg::NH_HOP || next_code == iphp_pkg::NH_ROUTE ||
                next_code == iphp_pkg::NH_FRAG || next_code == iphp_pkg::NH_DEST)
                phase = iphp_pkg::PH_EXT;
            else if (next_code == iphp_pkg::NH_TCP || next_code == iphp_pkg::NH_UDP)
                phase = iphp_pkg::PH_TRANS;
            else
                phase = iphp_pkg::PH_OTHER;
            ext_left = '0;
        endfunction

        function void parse_byte(logic [7:0] b);
            logic [15:0] rel;
            logic [15:0] trans_last;
            int          k;
            rel = byte_pos - hdr_end;
            trans_last = (next_code == iphp_pkg::NH_TCP) ? iphp_pkg::TCP_LAST
                                                         : iphp_pkg::UDP_LAST;
            case (phase)
                iphp_pkg::PH_FIXED:
                begin
                    if (byte_pos == 0 && b[7:4] == iphp_pkg::VERSION_IPV4)
                    begin
                        phase = iphp_pkg::PH_IPV4;
                    end
                    else
                    begin
                        if (byte_pos < 4)
                        begin
                            word0 = {word0[23:0], b};
                        end
                        else if (byte_pos == 6)
                        begin
                            next_code = b;
                        end
                        else if (byte_pos >= 8 && byte_pos < 24)
                        begin
                            k = (int'(byte_pos) - 8) / 8;
                            src_addr[k] = {src_addr[k][55:0], b};
                        end
                        else if (byte_pos >= 24 && byte_pos < iphp_pkg::FIXED_LEN)
                        begin
                            k = (int'(byte_pos) - 24) / 8;
                            dst_addr[k] = {dst_addr[k][55:0], b};
                        end
                        if (byte_pos == iphp_pkg::FIXED_LAST)
                        begin
                            hdr_end = iphp_pkg::FIXED_LEN;
                            select_next();
                        end
                    end
                end
                iphp_pkg::PH_EXT:
                begin
                    if (rel == 0)
                        ext_code = b;
                    else if (rel == 1)
                        ext_left = 12'((int'(b) + 1) * 8 - 2);
                    else if (ext_left != 0)
                        ext_left = ext_left - 12'd1;
                    if (rel >= 1 && ext_left == 0)
                    begin
                        hdr_end   = byte_pos + 16'd1;
                        next_code = ext_code;
                        select_next();
                    end
                end
                iphp_pkg::PH_TRANS:
                begin
                    if (rel < 4)
                        ports = {ports[23:0], b};
                    if (rel == trans_last)
                    begin
                        hdr_end = byte_pos + 16'd1;
                        phase   = iphp_pkg::PH_DONE;
                    end
                end
                default: ;
            endcase
        endfunction

        // accepted input beat
        function void take_byte(logic [7:0] b, logic lst);
            iphp_pkg::record_t rec;
            if (byte_pos < iphp_pkg::MAX_PACKET_BYTES_DEF)
            begin
                parse_byte(b);
                byte_pos = byte_pos + 16'd1;
            end
            if (lst)
            begin
                rec = '0;
                if (phase == iphp_pkg::PH_IPV4)
                begin
                    rec.parse_status = iphp_pkg::STAT_IPV4;
                end
                else if (phase == iphp_pkg::PH_FIXED)
                begin
                    rec.parse_status = iphp_pkg::STAT_TRUNC;
                end
                else
                begin
                    if (phase == iphp_pkg::PH_DONE)
                        rec.parse_status = iphp_pkg::STAT_OK;
                    else if (phase == iphp_pkg::PH_TRANS)
                        rec.parse_status = iphp_pkg::STAT_TRUNC;
                    else
                        rec.parse_status = iphp_pkg::STAT_NONE;
                    rec.proto_code = next_code;
                    if (phase == iphp_pkg::PH_DONE)
                    begin
                        rec.source_port      = ports[31:16];
                        rec.destination_port = ports[15:0];
                    end
                    rec.tclass         = word0[27:20];
                    rec.flow_label     = word0[19:0];
                    rec.src_addr_high  = src_addr[0];
                    rec.src_addr_low   = src_addr[1];
                    rec.dst_addr_high  = dst_addr[0];
                    rec.dst_addr_low   = dst_addr[1];
                    rec.payload_offset = hdr_end;
                    rec.payload_length = byte_pos - hdr_end;
                end
                awaited_records.push_back(rec);
                start_packet();
            end
        endfunction

        function int pending();
            return awaited_records.size();
        endfunction

        task report_mismatch(string msg);
            if (mismatch_count < 100)
                $display("%0t mismatch: %s", $realtime, msg);
            mismatch_count++;
        endtask

        task match(string field, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h want %0h", field, got, want));
        endtask

        // accepted result beat
        task check_record(iphp_pkg::record_t got);
            iphp_pkg::record_t want;
            if (awaited_records.size() == 0)
            begin
                report_mismatch("record with no packet closed");
            end
            else
            begin
                want = awaited_records.pop_front();
                match("parse_status", got.parse_status, want.parse_status);
                match("proto_code", got.proto_code, want.proto_code);
                match("source_port", got.source_port, want.source_port);
                match("destination_port", got.destination_port, want.destination_port);
                match("tclass", got.tclass, want.tclass);
                match("flow_label", got.flow_label, want.flow_label);
                match("src_addr_high", got.src_addr_high, want.src_addr_high);
                match("src_addr_low", got.src_addr_low, want.src_addr_low);
                match("dst_addr_high", got.dst_addr_high, want.dst_addr_high);
                match("dst_addr_low", got.dst_addr_low, want.dst_addr_low);
                match("payload_offset", got.payload_offset, want.payload_offset);
                match("payload_length", got.payload_length, want.payload_length);
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  packet_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  parse_status;
    logic [7:0]  proto_code;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [7:0]  tclass;
    logic [19:0] flow_label;
    logic [63:0] src_addr_high;
    logic [63:0] src_addr_low;
    logic [63:0] dst_addr_high;
    logic [63:0] dst_addr_low;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;

    logic              hold_start = 1'b0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                quiet_cycles = 0;
    iphp_pkg::record_t seen;

    parse_record_board board = new();

    ipv6_transport_header_parser dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .packet_byte      (packet_byte),
        .last_byte        (last_byte),
        .empty            (empty),
        .pop              (pop),
        .parse_status     (parse_status),
        .proto_code       (proto_code),
        .source_port      (source_port),
        .destination_port (destination_port),
        .tclass           (tclass),
        .flow_label       (flow_label),
        .src_addr_high    (src_addr_high),
        .src_addr_low     (src_addr_low),
        .dst_addr_high    (dst_addr_high),
        .dst_addr_low     (dst_addr_low),
        .payload_offset   (payload_offset),
        .payload_length   (payload_length)
    );

    assign seen = {parse_status, proto_code, source_port, destination_port,
                   tclass, flow_label, src_addr_high, src_addr_low,
                   dst_addr_high, dst_addr_low, payload_offset, payload_length};

    initial
    begin
        forever #5 clk = ~clk;
    end

    // beat monitor and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                board.take_byte(packet_byte, last_byte);
            if (pop && !empty)
                board.check_record(seen);
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("ipv6_transport_header_parser_tb NOT OK");
                $finish;
            end
        end
    end

    // result side; a long hold is counted here once requested
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_start)
                hold_left = HOLD_CYCLES;
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push        <= 1'b1;
        packet_byte <= b;
        last_byte   <= lst;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_packet(input byte_q_t p);
        for (int i = 0; i < p.size(); i++)
            send_byte(p[i], i == p.size() - 1);
    endtask

    // stop offering and wait for every record to come out
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    function automatic void add_random(ref byte_q_t p, input int n);
        for (int i = 0; i < n; i++)
            p.push_back(8'($urandom));
    endfunction

    function automatic byte_q_t fixed_header(logic [3:0] version, logic [7:0] nh);
        byte_q_t p;
        add_random(p, 40);
        p[0] = {version, p[0][3:0]};
        p[6] = nh;
        return p;
    endfunction

    function automatic void add_ext(ref byte_q_t p, input logic [7:0] nh,
                                    input logic [7:0] len);
        p.push_back(nh);
        p.push_back(len);
        add_random(p, (int'(len) + 1) * 8 - 2);
    endfunction

    function automatic logic [7:0] pick_ext();
        case ($urandom_range(3))
            0: return iphp_pkg::NH_HOP;
            1: return iphp_pkg::NH_ROUTE;
            2: return iphp_pkg::NH_FRAG;
            default: return iphp_pkg::NH_DEST;
        endcase
    endfunction

    function automatic byte_q_t random_packet();
        byte_q_t     p;
        int          r;
        int          n_ext;
        int          n;
        logic [3:0]  version;
        logic [7:0]  last_code;
        logic [7:0]  code;
        logic [7:0]  len;
        r = $urandom_range(99);
        if (r < 8)
        begin
            add_random(p, $urandom_range(1, 60));
            return p;
        end
        r = $urandom_range(99);
        version = (r < 85) ? 4'd6 : (r < 93) ? iphp_pkg::VERSION_IPV4 : 4'($urandom);
        n_ext = $urandom_range(0, 2);
        r = $urandom_range(99);
        last_code = (r < 60) ? iphp_pkg::NH_TCP : (r < 90) ? iphp_pkg::NH_UDP : 8'($urandom);
        code = (n_ext > 0) ? pick_ext() : last_code;
        p = fixed_header(version, code);
        for (int i = 0; i < n_ext; i++)
        begin
            code = (i == n_ext - 1) ? last_code : pick_ext();
            len = ($urandom_range(49) == 0) ? 8'($urandom_range(0, 15))
                                            : 8'($urandom_range(0, 3));
            add_ext(p, code, len);
        end
        if (last_code == iphp_pkg::NH_TCP)
            add_random(p, 20);
        else if (last_code == iphp_pkg::NH_UDP)
            add_random(p, 8);
        else
            add_random(p, $urandom_range(0, 16));
        add_random(p, $urandom_range(0, 8));
        if ($urandom_range(99) < 20)
        begin
            n = $urandom_range(1, p.size());
            p = p[0:n-1];
        end
        return p;
    endfunction

    task automatic run_random(input int packets);
        repeat (packets)
            send_packet(random_packet());
    endtask

    initial
    begin : stimulus
        byte_q_t p;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 8;
        recv_idle_pct = 62;

        // single-beat packets: IPv6 cut short, IPv4
        p = {8'h60};
        send_packet(p);
        p = {8'h45};
        send_packet(p);
        // IPv4 with a body that must be ignored
        p = fixed_header(iphp_pkg::VERSION_IPV4, iphp_pkg::NH_TCP);
        add_random(p, 4);
        send_packet(p);
        // cut inside the fixed header
        p = fixed_header(4'd6, iphp_pkg::NH_TCP);
        p = p[0:19];
        send_packet(p);
        // ends with the fixed header, transport not started
        p = fixed_header(4'd6, iphp_pkg::NH_TCP);
        send_packet(p);
        // ends where a hop-by-hop header would start
        p = fixed_header(4'd6, iphp_pkg::NH_HOP);
        send_packet(p);
        // TCP, no payload
        p = fixed_header(4'd6, iphp_pkg::NH_TCP);
        add_random(p, 20);
        send_packet(p);
        // UDP with payload
        p = fixed_header(4'd6, iphp_pkg::NH_UDP);
        add_random(p, 10);
        send_packet(p);
        // cut inside the TCP ports
        p = fixed_header(4'd6, iphp_pkg::NH_TCP);
        add_random(p, 2);
        send_packet(p);
        // every extension kind, then TCP
        p = fixed_header(4'd6, iphp_pkg::NH_HOP);
        add_ext(p, iphp_pkg::NH_ROUTE, 8'd0);
        add_ext(p, iphp_pkg::NH_FRAG, 8'd1);
        add_ext(p, iphp_pkg::NH_DEST, 8'd0);
        add_ext(p, iphp_pkg::NH_TCP, 8'd2);
        add_random(p, 25);
        send_packet(p);
        // cut inside an extension header
        p = fixed_header(4'd6, iphp_pkg::NH_ROUTE);
        add_ext(p, iphp_pkg::NH_UDP, 8'd3);
        p = p[0:p.size()-10];
        send_packet(p);
        // unparsed protocol
        p = fixed_header(4'd6, 8'd58);
        add_random(p, 6);
        send_packet(p);
        // long extension header, then UDP
        p = fixed_header(4'd6, iphp_pkg::NH_DEST);
        add_ext(p, iphp_pkg::NH_UDP, 8'h07);
        add_random(p, 8);
        send_packet(p);
        // all ones: version 15, max class, label and addresses
        p = {};
        repeat (44) p.push_back(8'hff);
        send_packet(p);
        // all zeros: version 0, endless hop-by-hop chain
        p = {};
        repeat (48) p.push_back(8'h00);
        send_packet(p);
        // UDP with extreme ports, ending on its last header byte
        p = fixed_header(4'd6, iphp_pkg::NH_UDP);
        p.push_back(8'hff);
        p.push_back(8'hff);
        p.push_back(8'h00);
        p.push_back(8'h00);
        add_random(p, 4);
        send_packet(p);
        p = fixed_header(4'd6, iphp_pkg::NH_TCP);
        p.push_back(8'h00);
        p.push_back(8'h00);
        p.push_back(8'hff);
        p.push_back(8'hff);
        add_random(p, 16);
        send_packet(p);
        drain();

        // receiver holds off while short packets pile up behind it
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        repeat (24)
            send_byte(8'($urandom), 1'b1);
        drain();

        run_random(2);
        drain();

        send_idle_pct = 62;
        recv_idle_pct = 8;
        run_random(2);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(2);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.mismatch_count == 0)
            $display("ipv6_transport_header_parser_tb OK");
        else
            $display("ipv6_transport_header_parser_tb NOT OK");
        $finish;
    end

endmodule

FILE: ipv6_transport_header_parser.f
+incdir+hw/rtl
hw/rtl/iphp_pkg.sv
hw/rtl/iphp_fifo.sv
hw/rtl/iphp_front.sv
hw/rtl/iphp_back.sv
hw/rtl/ipv6_transport_header_parser.sv
tb/sv/ipv6_transport_header_parser_tb.sv
